// ===== design/lsas_pkg.sv =====
package lsas_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned MS_W    = 16;
	localparam int unsigned POWER_W = 7;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		CMD_KEEP   = 2'd0,
		CMD_OPEN   = 2'd1,
		CMD_CLOSE  = 2'd2,
		CMD_CANCEL = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REQ_NONE  = 2'd0,
		REQ_OPEN  = 2'd1,
		REQ_CLOSE = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_FWD  = 2'd1,
		ACT_BWD  = 2'd2,
		ACT_STOP = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_READY   = 3'd1,
		PH_OPENING = 3'd2,
		PH_CLOSING = 3'd3,
		PH_ERROR   = 3'd4
	} phase_t;

	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_WINDOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TIMEOUT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_RUN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_POWER   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_LEVEL  = 3'd4;

	localparam logic [MS_W-1:0]    OPEN_WINDOW_RST   = 16'd200;
	localparam logic [MS_W-1:0]    CLOSE_TIMEOUT_RST = 16'd1000;
	localparam logic [MS_W-1:0]    OPEN_RUN_RST      = 16'd500;
	localparam logic [POWER_W-1:0] MOTOR_POWER_RST   = 7'd100;
	localparam logic [POWER_W-1:0] POWER_MAX         = 7'd100;

endpackage

// ===== design/lsas_if.sv =====
interface lsas_tick_if;
	logic                               valid;
	logic                               ready;
	lsas_pkg::cmd_t                     cmd;
	logic                               switch_level;
	logic [lsas_pkg::TIME_W-1:0]        now_ms;

	modport source (output valid, cmd, switch_level, now_ms, input ready);
	modport sink   (input valid, cmd, switch_level, now_ms, output ready);
endinterface

interface lsas_result_if;
	logic                               valid;
	logic                               ready;
	lsas_pkg::act_t                     motor_action;
	logic [lsas_pkg::POWER_W-1:0]       drive_power;
	logic [lsas_pkg::MS_W-1:0]          run_limit_ms;
	lsas_pkg::phase_t                   phase;
	lsas_pkg::req_t                     pending_request;

	modport source (output valid, motor_action, drive_power, run_limit_ms, phase,
		pending_request, input ready);
	modport sink   (input valid, motor_action, drive_power, run_limit_ms, phase,
		pending_request, output ready);
endinterface

// ===== design/limit_switch_actuator_sequencer.sv =====
// Lid actuator sequencer, one supervision tick per beat on the tick channel.
// A tick beat carries a command update, the sampled limit switch level and
// the free running millisecond time; each tick gives exactly one beat on the
// result channel with the motor action, its power and run limit, the phase
// after the tick and the pending request.
// Configuration (window, timeout, run limit, power, closed level) is written
// through cfg_we / cfg_idx / cfg_data; the user must write it only while no
// tick is in flight, as the block itself does not enforce this.
// A tick accepted is registered in the input stage, worked on combinationally
// and loaded into the result register, which drives the result channel.
// Throughput: one tick per cycle while the result receiver does not stall;
// the phase, start time and pending request are updated in the same cycle
// the result register is loaded, so the next tick sees them at once.
// Reset puts the block in idle with no pending request, start time zero and
// the configuration at its defaults.
// When the result receiver stalls, the result register holds its beat, the
// input stage holds its tick, and tick.ready drops once both are full.
module limit_switch_actuator_sequencer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lsas_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [lsas_pkg::CFG_DATA_W-1:0]    cfg_data,
	lsas_tick_if.sink                          tick,
	lsas_result_if.source                      result
);

	// configuration registers
	logic [lsas_pkg::MS_W-1:0]    open_window_q;
	logic [lsas_pkg::MS_W-1:0]    close_timeout_q;
	logic [lsas_pkg::MS_W-1:0]    open_run_q;
	logic [lsas_pkg::POWER_W-1:0] motor_power_q;
	logic                         closed_level_q;

	// sequencer state
	lsas_pkg::phase_t             phase_q;
	logic [lsas_pkg::TIME_W-1:0]  start_q;
	lsas_pkg::req_t               pend_q;

	// input stage
	logic                         valid_s1;
	lsas_pkg::cmd_t               cmd_s1;
	logic                         switch_s1;
	logic [lsas_pkg::TIME_W-1:0]  now_s1;

	// result stage
	logic                         valid_s2;
	lsas_pkg::act_t               action_s2;
	logic [lsas_pkg::POWER_W-1:0] power_s2;
	logic [lsas_pkg::MS_W-1:0]    runlim_s2;
	lsas_pkg::phase_t             phase_s2;
	lsas_pkg::req_t               pend_s2;

	logic                         load_s2;
	logic                         load_s1;

	// next values
	lsas_pkg::req_t               pend_cmd;
	lsas_pkg::req_t               pend_d;
	lsas_pkg::phase_t             phase_d;
	logic                         start_we;
	lsas_pkg::act_t               action_d;
	logic [lsas_pkg::POWER_W-1:0] power_d;
	logic [lsas_pkg::MS_W-1:0]    runlim_d;
	logic [lsas_pkg::POWER_W-1:0] start_power;
	logic [lsas_pkg::TIME_W-1:0]  elapsed;
	logic                         stable;
	logic                         closed;
	logic                         window_done;
	logic                         timeout_done;

	assign load_s2    = !valid_s2 || result.ready;
	assign load_s1    = !valid_s1 || load_s2;
	assign tick.ready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_window_q   <= lsas_pkg::OPEN_WINDOW_RST;
			close_timeout_q <= lsas_pkg::CLOSE_TIMEOUT_RST;
			open_run_q      <= lsas_pkg::OPEN_RUN_RST;
			motor_power_q   <= lsas_pkg::MOTOR_POWER_RST;
			closed_level_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				lsas_pkg::CFG_OPEN_WINDOW:   open_window_q   <= cfg_data;
				lsas_pkg::CFG_CLOSE_TIMEOUT: close_timeout_q <= cfg_data;
				lsas_pkg::CFG_OPEN_RUN:      open_run_q      <= cfg_data;
				lsas_pkg::CFG_MOTOR_POWER:   motor_power_q   <= cfg_data[lsas_pkg::POWER_W-1:0];
				lsas_pkg::CFG_CLOSED_LEVEL:  closed_level_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && tick.valid) begin
			cmd_s1    <= tick.cmd;
			switch_s1 <= tick.switch_level;
			now_s1    <= tick.now_ms;
		end
	end

	assign start_power  = (motor_power_q > lsas_pkg::POWER_MAX) ? lsas_pkg::POWER_MAX
		: motor_power_q;
	assign elapsed      = now_s1 - start_q;
	assign closed       = (switch_s1 == closed_level_q);
	assign stable       = (phase_q == lsas_pkg::PH_IDLE) || (phase_q == lsas_pkg::PH_READY);
	assign window_done  = elapsed >= {{(lsas_pkg::TIME_W-lsas_pkg::MS_W){1'b0}}, open_window_q};
	assign timeout_done = elapsed >= {{(lsas_pkg::TIME_W-lsas_pkg::MS_W){1'b0}}, close_timeout_q};

	always_comb begin
		case (cmd_s1)
			lsas_pkg::CMD_OPEN:   pend_cmd = lsas_pkg::REQ_OPEN;
			lsas_pkg::CMD_CLOSE:  pend_cmd = lsas_pkg::REQ_CLOSE;
			lsas_pkg::CMD_CANCEL: pend_cmd = lsas_pkg::REQ_NONE;
			default:              pend_cmd = pend_q;
		endcase
	end

	always_comb begin
		pend_d   = pend_cmd;
		phase_d  = phase_q;
		start_we = 1'b0;
		action_d = lsas_pkg::ACT_NONE;
		power_d  = '0;
		runlim_d = '0;
		if (stable && pend_cmd == lsas_pkg::REQ_OPEN) begin
			start_we = 1'b1;
			phase_d  = lsas_pkg::PH_OPENING;
			action_d = lsas_pkg::ACT_FWD;
			power_d  = start_power;
			runlim_d = open_run_q;
		end else if (stable && pend_cmd == lsas_pkg::REQ_CLOSE) begin
			// already closed: report ready, the request stays pending
			if (closed) begin
				phase_d = lsas_pkg::PH_READY;
			end else begin
				start_we = 1'b1;
				phase_d  = lsas_pkg::PH_CLOSING;
				action_d = lsas_pkg::ACT_BWD;
				power_d  = start_power;
			end
		end else if (phase_q == lsas_pkg::PH_OPENING) begin
			if (window_done) begin
				action_d = lsas_pkg::ACT_STOP;
				phase_d  = lsas_pkg::PH_IDLE;
				pend_d   = lsas_pkg::REQ_NONE;
			end
		end else if (phase_q == lsas_pkg::PH_CLOSING) begin
			// switch wins over the timeout on the same tick
			if (closed) begin
				action_d = lsas_pkg::ACT_STOP;
				phase_d  = lsas_pkg::PH_READY;
				pend_d   = lsas_pkg::REQ_NONE;
			end else if (timeout_done) begin
				action_d = lsas_pkg::ACT_STOP;
				phase_d  = lsas_pkg::PH_ERROR;
				pend_d   = lsas_pkg::REQ_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lsas_pkg::PH_IDLE;
			start_q  <= '0;
			pend_q   <= lsas_pkg::REQ_NONE;
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				phase_q <= phase_d;
				pend_q  <= pend_d;
				if (start_we) begin
					start_q <= now_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			action_s2 <= action_d;
			power_s2  <= power_d;
			runlim_s2 <= runlim_d;
			phase_s2  <= phase_d;
			pend_s2   <= pend_d;
		end
	end

	assign result.valid           = valid_s2;
	assign result.motor_action    = action_s2;
	assign result.drive_power     = power_s2;
	assign result.run_limit_ms    = runlim_s2;
	assign result.phase           = phase_s2;
	assign result.pending_request = pend_s2;

	// error is left only by reset
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == lsas_pkg::PH_ERROR |=> phase_q == lsas_pkg::PH_ERROR)
		else $error("error phase was left without reset");

	a_none_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && action_s2 == lsas_pkg::ACT_NONE |-> power_s2 == '0 && runlim_s2 == '0)
		else $error("drive values on a beat with no motor action");

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && action_s2 == lsas_pkg::ACT_STOP |-> pend_s2 == lsas_pkg::REQ_NONE)
		else $error("stop beat left a pending request");

	a_fwd_opening: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && action_s2 == lsas_pkg::ACT_FWD |-> phase_s2 == lsas_pkg::PH_OPENING)
		else $error("forward start without opening phase");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!tick.ready |-> valid_s1 && valid_s2 && !result.ready)
		else $error("tick channel stalled with room in the pipeline");

endmodule
